// ----- rtl/separator_record_splitter_assert.svh -----
// Assertion macros for the separator record splitter.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef SEPARATOR_RECORD_SPLITTER_ASSERT_SVH
`define SEPARATOR_RECORD_SPLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("separator_record_splitter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("separator_record_splitter: next-cycle check failed");

`endif

// ----- rtl/srs_pkg.sv -----
package srs_pkg;

  localparam int unsigned MAX_SEP_BYTES = 8;
  localparam int unsigned OFFSET_BITS   = 32;
  localparam int unsigned OUT_BITS      = 32;
  localparam int unsigned SEP_LEN_BITS  = 4;
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned CFG_INDEX_BITS = 1;

  localparam int unsigned LEN_BITS      = $clog2(MAX_SEP_BYTES + 1);
  localparam int unsigned WIN_DEPTH     = (MAX_SEP_BYTES > 1) ? MAX_SEP_BYTES - 1 : 1;
  localparam int unsigned CAND_IDX_BITS = (MAX_SEP_BYTES > 1) ? $clog2(MAX_SEP_BYTES) : 1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_BITS-1:0] REG_SEP_BYTES  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEP_LENGTH = CFG_INDEX_BITS'(1);

  typedef logic [OFFSET_BITS-1:0] ofs_t;
  typedef logic [LEN_BITS-1:0]    len_t;

  // One classified byte as it travels from the front end to the back end.
  typedef struct packed {
    logic hit;
    logic last;
    ofs_t start;
    ofs_t pos;
  } cls_t;

  function automatic len_t active_len(logic [SEP_LEN_BITS-1:0] raw);
    len_t res;
    if (raw == '0) begin
      res = len_t'(1);
    end else if (raw > SEP_LEN_BITS'(MAX_SEP_BYTES)) begin
      res = len_t'(MAX_SEP_BYTES);
    end else begin
      res = len_t'(raw);
    end
    return res;
  endfunction

  function automatic logic [OUT_BITS-1:0] to_out(ofs_t v);
    return OUT_BITS'(v);
  endfunction

endpackage

// ----- rtl/srs_if.sv -----
interface srs_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface srs_rec_if import srs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] record_first;
  logic [OUT_BITS-1:0] record_last;
  logic                tail_record;
  logic                run_end;

  modport source (output valid, output record_first, output record_last,
                  output tail_record, output run_end, input ready);
  modport sink (input valid, input record_first, input record_last,
                input tail_record, input run_end, output ready);
endinterface

interface srs_cfg_if import srs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/srs_front.sv -----
module srs_front import srs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  srs_byte_if.sink                 byte_i,
  input  logic [CFG_DATA_BITS-1:0] sep_bytes_i,
  input  len_t                     sep_len_i,
  input  logic                     queue_full_i,
  output logic                     push_o,
  output cls_t                     push_data_o
);

  logic [7:0] win_q [WIN_DEPTH];
  logic [7:0] win_d [WIN_DEPTH];
  logic [7:0] cand [MAX_SEP_BYTES];
  ofs_t       pos_q, pos_d;
  ofs_t       len_m1;
  len_t       idx;
  logic       equal;
  logic       accept;

  assign byte_i.ready = !queue_full_i;
  assign accept       = byte_i.valid && !queue_full_i;
  assign len_m1       = ofs_t'(sep_len_i) - ofs_t'(1);

  always_comb begin
    cand[0] = byte_i.data_byte;
    for (int j = 1; j < MAX_SEP_BYTES; j++) begin
      cand[j] = win_q[j-1];
    end
  end

  // Separator byte i lines up with the byte seen len-1-i items ago.
  always_comb begin
    equal = 1'b1;
    idx   = '0;
    for (int i = 0; i < MAX_SEP_BYTES; i++) begin
      idx = sep_len_i - len_t'(i) - len_t'(1);
      if (len_t'(i) < sep_len_i &&
          sep_bytes_i[8*i +: 8] != cand[idx[CAND_IDX_BITS-1:0]]) begin
        equal = 1'b0;
      end
    end
  end

  assign push_o            = accept;
  assign push_data_o.hit   = (pos_q >= len_m1) && equal;
  assign push_data_o.last  = byte_i.final_byte;
  assign push_data_o.start = pos_q - len_m1;
  assign push_data_o.pos   = pos_q;

  always_comb begin
    win_d = win_q;
    pos_d = pos_q;
    if (accept) begin
      if (byte_i.final_byte) begin
        for (int k = 0; k < WIN_DEPTH; k++) begin
          win_d[k] = 8'h00;
        end
        pos_d = '0;
      end else begin
        win_d[0] = byte_i.data_byte;
        for (int k = 1; k < WIN_DEPTH; k++) begin
          win_d[k] = win_q[k-1];
        end
        pos_d = pos_q + ofs_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_q[k] <= 8'h00;
      end
      pos_q <= '0;
    end else begin
      win_q <= win_d;
      pos_q <= pos_d;
    end
  end

endmodule

// ----- rtl/srs_queue.sv -----
module srs_queue import srs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t push_data_i,
  input  logic pop_i,
  output cls_t head_o,
  output logic full_o,
  output logic empty_o
);

  cls_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QPTR_BITS:0]   cnt_q;

  assign full_o  = cnt_q == (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_BITS + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_BITS + 1)'(1);
      end
    end
  end

endmodule

// ----- rtl/srs_back.sv -----
module srs_back import srs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  len_t     sep_len_i,
  input  logic     queue_empty_i,
  input  cls_t     head_i,
  output logic     pop_o,
  output logic     pend_o,
  srs_rec_if.source rec_o
);

  ofs_t                begin_q, begin_d;
  ofs_t                resume_q, resume_d;
  logic                pend_q, pend_d;
  ofs_t                pend_first_q, pend_first_d;
  ofs_t                pend_last_q, pend_last_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0] first_q, first_d;
  logic [OUT_BITS-1:0] last_q, last_d;
  logic                tail_q, tail_d;
  logic                end_q, end_d;

  ofs_t start_m1;
  ofs_t begin_new;
  logic sep_emit;
  logic tail_emit;
  logic can_load;
  logic pop;

  assign can_load  = !out_valid_q || rec_o.ready;
  assign start_m1  = head_i.start - ofs_t'(1);
  assign sep_emit  = head_i.hit && (head_i.start >= resume_q) &&
                     (head_i.start != '0) && (start_m1 > begin_q);
  assign begin_new = sep_emit ? head_i.start : begin_q;
  assign tail_emit = head_i.last && (head_i.pos > begin_new);
  assign pop       = !queue_empty_i && !pend_q && can_load;

  always_comb begin
    begin_d      = begin_q;
    resume_d     = resume_q;
    pend_d       = pend_q;
    pend_first_d = pend_first_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q && !rec_o.ready;
    first_d      = first_q;
    last_d       = last_q;
    tail_d       = tail_q;
    end_d        = end_q;
    if (pend_q && can_load) begin
      out_valid_d = 1'b1;
      first_d     = to_out(pend_first_q);
      last_d      = to_out(pend_last_q);
      tail_d      = 1'b1;
      end_d       = 1'b1;
      pend_d      = 1'b0;
    end else if (pop) begin
      if (head_i.last) begin
        begin_d  = '0;
        resume_d = '0;
      end else if (sep_emit) begin
        begin_d  = head_i.start;
        resume_d = head_i.start + ofs_t'(sep_len_i);
      end
      if (sep_emit) begin
        out_valid_d  = 1'b1;
        first_d      = to_out(begin_q);
        last_d       = to_out(start_m1);
        tail_d       = 1'b0;
        end_d        = !tail_emit;
        pend_d       = tail_emit;
        pend_first_d = head_i.start;
        pend_last_d  = head_i.pos;
      end else if (tail_emit) begin
        out_valid_d = 1'b1;
        first_d     = to_out(begin_q);
        last_d      = to_out(head_i.pos);
        tail_d      = 1'b1;
        end_d       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q     <= '0;
      resume_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      begin_q     <= begin_d;
      resume_q    <= resume_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_first_q <= pend_first_d;
    pend_last_q  <= pend_last_d;
    first_q      <= first_d;
    last_q       <= last_d;
    tail_q       <= tail_d;
    end_q        <= end_d;
  end

  assign pop_o              = pop;
  assign pend_o             = pend_q;
  assign rec_o.valid        = out_valid_q;
  assign rec_o.record_first = first_q;
  assign rec_o.record_last  = last_q;
  assign rec_o.tail_record  = tail_q;
  assign rec_o.run_end      = end_q;

endmodule

// ----- rtl/separator_record_splitter.sv -----
// Splits a byte stream into records at each accepted occurrence of a separator of one to
// eight bytes and reports every record as its first and last byte offset. The block takes
// one byte per cycle while the queue is not full: the front end compares the separator
// combinationally against the newest bytes and writes the result into a four-entry queue,
// and the back end retires one queued byte per cycle, while its output is free and no tail
// record is pending, into a registered output. A byte that closes both a separator record
// and the tail record of the file holds the tail record pending until the output is free,
// so with no stall on the output the sustained rate is one item per cycle except at such a
// file end. A result passes through the queue and then the output register. Configuration
// writes are always taken and must be made while no bytes are in flight.
module separator_record_splitter import srs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  srs_byte_if.sink  byte_i,
  srs_cfg_if.sink   cfg_i,
  srs_rec_if.source record_o
);

  logic [CFG_DATA_BITS-1:0] sep_bytes_q, sep_bytes_d;
  logic [SEP_LEN_BITS-1:0]  sep_len_q, sep_len_d;
  len_t                     sep_len_eff;

  logic queue_push;
  cls_t queue_push_data;
  logic queue_pop;
  cls_t queue_head;
  logic queue_full;
  logic queue_empty;
  logic back_pend;

  assign cfg_i.ready = 1'b1;
  assign sep_len_eff = active_len(sep_len_q);

  always_comb begin
    sep_bytes_d = sep_bytes_q;
    sep_len_d   = sep_len_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SEP_BYTES: begin
          sep_bytes_d = cfg_i.data;
        end
        REG_SEP_LENGTH: begin
          sep_len_d = cfg_i.data[SEP_LEN_BITS-1:0];
        end
        default: begin
          sep_bytes_d = sep_bytes_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_bytes_q <= '0;
      sep_len_q   <= SEP_LEN_BITS'(1);
    end else begin
      sep_bytes_q <= sep_bytes_d;
      sep_len_q   <= sep_len_d;
    end
  end

  srs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .sep_bytes_i  (sep_bytes_q),
    .sep_len_i    (sep_len_eff),
    .queue_full_i (queue_full),
    .push_o       (queue_push),
    .push_data_o  (queue_push_data)
  );

  srs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (queue_push),
    .push_data_i (queue_push_data),
    .pop_i       (queue_pop),
    .head_o      (queue_head),
    .full_o      (queue_full),
    .empty_o     (queue_empty)
  );

  srs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sep_len_i     (sep_len_eff),
    .queue_empty_i (queue_empty),
    .head_i        (queue_head),
    .pop_o         (queue_pop),
    .pend_o        (back_pend),
    .rec_o         (record_o)
  );

`include "separator_record_splitter_assert.svh"

  `SRS_ASSERT_IMP(a_tail_closes_run, record_o.valid && record_o.tail_record, record_o.run_end)
  `SRS_ASSERT_IMP(a_pend_keeps_output, back_pend, record_o.valid)
  `SRS_ASSERT_IMP(a_pend_blocks_pop, back_pend, !queue_pop)
  `SRS_ASSERT_NEXT(a_pend_drains, back_pend && record_o.ready, !back_pend && record_o.valid && record_o.tail_record)

endmodule

// ----- tb/sv/tb_separator_record_splitter.sv -----
`timescale 1ns / 100ps

module tb_separator_record_splitter;
  import srs_pkg::*;

  localparam int unsigned CLK_PERIOD     = 2;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned RANDOM_ITEMS   = 1500;
  localparam int unsigned PHASE_ITEMS    = 120;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 50;

  typedef struct packed {
    logic [OUT_BITS-1:0] rec_first;
    logic [OUT_BITS-1:0] rec_last;
    logic                tail;
    logic                run_end;
  } record_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n;

  srs_byte_if byte_if ();
  srs_cfg_if  cfg_if ();
  srs_rec_if  rec_if ();

  separator_record_splitter dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .byte_i   (byte_if),
    .cfg_i    (cfg_if),
    .record_o (rec_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  record_t                  expected_records[$];
  logic [CFG_DATA_BITS-1:0] sep_pattern;
  logic [SEP_LEN_BITS-1:0]  sep_len_raw;
  logic [7:0]               history[MAX_SEP_BYTES-1];
  ofs_t                     byte_pos;
  ofs_t                     rec_begin;
  ofs_t                     resume_pos;
  logic [7:0]               alphabet[3];
  int unsigned              items_sent;
  int unsigned              burst_left;
  int unsigned              error_count;
  int unsigned              idle_cycles;
  bit                       steady_sender;

  function automatic int used_length();
    int n;
    n = int'(sep_len_raw);
    if (n < 1) begin
      n = 1;
    end else if (n > int'(MAX_SEP_BYTES)) begin
      n = int'(MAX_SEP_BYTES);
    end
    return n;
  endfunction

  function automatic logic [SEP_LEN_BITS-1:0] random_length();
    logic [SEP_LEN_BITS-1:0] n;
    case ($urandom_range(0, 9))
      0: n = '0;
      1: n = SEP_LEN_BITS'(1);
      2: n = SEP_LEN_BITS'(MAX_SEP_BYTES);
      3: n = '1;
      default: n = SEP_LEN_BITS'($urandom_range(2, MAX_SEP_BYTES - 1));
    endcase
    return n;
  endfunction

  function automatic logic [7:0] content_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 6) begin
      b = alphabet[$urandom_range(0, 2)];
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  task automatic clear_file_state();
    foreach (history[i]) history[i] = '0;
    byte_pos   = '0;
    rec_begin  = '0;
    resume_pos = '0;
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t ns: record check: %s", $time, msg);
    end
  endtask

  task automatic predict_records(input logic [7:0] value, input logic is_final);
    int      len;
    bit      hit;
    ofs_t    q;
    int      n;
    record_t r;
    logic [7:0] want;
    logic [7:0] have;
    len = used_length();
    n = 0;
    hit = (byte_pos >= ofs_t'(len - 1));
    for (int i = 0; i < len && hit; i++) begin
      want = sep_pattern[8*i +: 8];
      if (i == len - 1) begin
        have = value;
      end else begin
        have = history[len - 2 - i];
      end
      if (want != have) hit = 1'b0;
    end
    if (hit) begin
      q = byte_pos - ofs_t'(len - 1);
      if (q >= resume_pos && q != '0 && (q - ofs_t'(1)) > rec_begin) begin
        r.rec_first = OUT_BITS'(rec_begin);
        r.rec_last  = OUT_BITS'(q - ofs_t'(1));
        r.tail      = 1'b0;
        r.run_end   = !is_final;
        expected_records.push_back(r);
        n++;
        rec_begin  = q;
        resume_pos = q + ofs_t'(len);
      end
    end
    if (is_final) begin
      if (byte_pos > rec_begin) begin
        r.rec_first = OUT_BITS'(rec_begin);
        r.rec_last  = OUT_BITS'(byte_pos);
        r.tail      = 1'b1;
        r.run_end   = 1'b1;
        expected_records.push_back(r);
      end else if (n > 0) begin
        expected_records[expected_records.size() - 1].run_end = 1'b1;
      end
      clear_file_state();
    end else begin
      for (int i = MAX_SEP_BYTES - 2; i > 0; i--) history[i] = history[i - 1];
      history[0] = value;
      byte_pos = byte_pos + ofs_t'(1);
    end
  endtask

  task automatic send_byte(input logic [7:0] value, input logic is_final);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        byte_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    byte_if.valid      = 1'b1;
    byte_if.data_byte  = value;
    byte_if.final_byte = is_final;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    items_sent++;
    predict_records(value, is_final);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == REG_SEP_BYTES) begin
      sep_pattern = value;
    end else begin
      sep_len_raw = value[SEP_LEN_BITS-1:0];
    end
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_results_idle();
    @(negedge clk);
    byte_if.valid = 1'b0;
    burst_left = 0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_file(input byte_q_t bytes, input bit close, input bit may_pause);
    foreach (bytes[i]) begin
      send_byte(bytes[i], close && (i == bytes.size() - 1));
      if (may_pause && i < bytes.size() - 1 && $urandom_range(0, 299) == 0) begin
        wait_results_idle();
        write_register(REG_SEP_LENGTH, CFG_DATA_BITS'(random_length()));
      end
    end
  endtask

  task automatic push_separator(inout byte_q_t bytes, input int count);
    for (int i = 0; i < count; i++) bytes.push_back(sep_pattern[8*i +: 8]);
  endtask

  task automatic send_random_file();
    byte_q_t     bytes;
    int unsigned kind;
    int unsigned records;
    int          len;
    len = used_length();
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      repeat ($urandom_range(1, 40)) bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) push_separator(bytes, len);
      records = $urandom_range(1, 6);
      for (int r = 0; r < records; r++) begin
        repeat ($urandom_range(0, 10)) bytes.push_back(content_byte());
        if (r < records - 1 || $urandom_range(0, 1) == 1) begin
          push_separator(bytes, (kind == 9) ? $urandom_range(0, len - 1) : len);
        end
      end
    end
    if (bytes.size() == 0) bytes.push_back(content_byte());
    send_file(bytes, 1'b1, 1'b1);
  endtask

  // Reset settings: a single zero byte separates records.
  task automatic test_single_byte_separator();
    send_file('{8'h00, 8'h41, 8'h42, 8'h00, 8'h00, 8'h43, 8'h00}, 1'b1, 1'b0);
    wait_results_idle();
  endtask

  // An oversized length acts as the longest separator, which ends on the final byte.
  task automatic test_long_separator();
    write_register(REG_SEP_BYTES, '1);
    write_register(REG_SEP_LENGTH, CFG_DATA_BITS'({SEP_LEN_BITS{1'b1}}));
    send_file('{8'h00, 8'h80, 8'h7f, 8'hff, 8'hff, 8'hff, 8'hff,
                8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 1'b0);
    wait_results_idle();
  endtask

  // The length changes to zero, which acts as one, while a file is open.
  task automatic test_config_mid_file();
    write_register(REG_SEP_BYTES, CFG_DATA_BITS'(16'h3b2c));
    write_register(REG_SEP_LENGTH, CFG_DATA_BITS'(2));
    send_file('{8'h41, 8'h42, 8'h2c}, 1'b0, 1'b0);
    wait_results_idle();
    write_register(REG_SEP_LENGTH, '0);
    send_file('{8'h2c, 8'h44}, 1'b1, 1'b0);
    wait_results_idle();
  endtask

  task automatic test_random_files();
    int unsigned target;
    int unsigned phase_end;
    logic [CFG_DATA_BITS-1:0] sep_value;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      wait_results_idle();
      foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 15))
        0: sep_value = '0;
        1: sep_value = '1;
        2, 3: sep_value = {$urandom, $urandom};
        default: begin
          for (int i = 0; i < MAX_SEP_BYTES; i++) begin
            sep_value[8*i +: 8] = alphabet[$urandom_range(0, 2)];
          end
        end
      endcase
      write_register(REG_SEP_BYTES, sep_value);
      write_register(REG_SEP_LENGTH, CFG_DATA_BITS'(random_length()));
      steady_sender = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_file();
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    logic [15:0] stall_bits;
    int unsigned tick;
    rec_if.ready = 1'b0;
    stall_bits = '1;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_bits = '1;
          1: stall_bits = 16'($urandom) | 16'h8001;
          default: stall_bits = 16'($urandom) | 16'h0001;
        endcase
      end
      rec_if.ready = stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[15:1]};
    end
  end

  always @(posedge clk) begin
    record_t want;
    if (rst_n && rec_if.valid && rec_if.ready) begin
      if (expected_records.size() == 0) begin
        report_error($sformatf("record %0d..%0d arrived with nothing expected",
                               rec_if.record_first, rec_if.record_last));
      end else begin
        want = expected_records.pop_front();
        if (rec_if.record_first !== want.rec_first) begin
          report_error($sformatf("record_first %0d, expected %0d",
                                 rec_if.record_first, want.rec_first));
        end
        if (rec_if.record_last !== want.rec_last) begin
          report_error($sformatf("record_last %0d, expected %0d",
                                 rec_if.record_last, want.rec_last));
        end
        if (rec_if.tail_record !== want.tail) begin
          report_error($sformatf("tail_record %b, expected %b",
                                 rec_if.tail_record, want.tail));
        end
        if (rec_if.run_end !== want.run_end) begin
          report_error($sformatf("run_end %b, expected %b", rec_if.run_end, want.run_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (byte_if.valid && byte_if.ready) || (rec_if.valid && rec_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = '0;
    byte_if.final_byte = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_SEP_BYTES;
    cfg_if.data        = '0;
    rst_n              = 1'b0;
    sep_pattern        = '0;
    sep_len_raw        = SEP_LEN_BITS'(1);
    items_sent         = 0;
    burst_left         = 0;
    error_count        = 0;
    idle_cycles        = 0;
    steady_sender      = 1'b0;
    foreach (alphabet[i]) alphabet[i] = '0;
    clear_file_state();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_byte_separator();
    test_long_separator();
    test_config_mid_file();
    test_random_files();
    wait_results_idle();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
